// ===== rtl/core/cms_pkg.sv =====
package cms_pkg;

  localparam int DEF_MAX_EDGE = 64;
  localparam int FACES        = 6;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  // one classified word waiting between front and back
  typedef struct packed {
    logic        op;
    logic [2:0]  face;
    logic        zero;
    logic [15:0] ma;
    logic [16:0] sx;
    logic [16:0] sy;
    logic [5:0]  tx;
    logic [5:0]  ty;
    logic [47:0] rgb;
  } qent_t;

  typedef struct packed {
    logic [47:0] rgb;
    logic [2:0]  face;
    logic        zero;
  } res_t;

endpackage

// ===== rtl/core/cms_ram.sv =====
module cms_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write returns the old word
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/cms_fifo.sv =====
module cms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             wr;
  logic             rd;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push & ~full;
  assign rd    = pop & ~empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/cms_front.sv =====
module cms_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [2:0]         face_index,
  input  logic [5:0]         texel_x,
  input  logic [5:0]         texel_y,
  input  logic [15:0]        red_in,
  input  logic [15:0]        green_in,
  input  logic [15:0]        blue_in,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  output logic               q_push,
  output cms_pkg::qent_t     q_data,
  input  logic               q_full
);

  logic                  held;
  cms_pkg::qent_t        ent;
  cms_pkg::qent_t        ent_next;
  logic                  take;
  logic signed [16:0]    ex, ey, ez, nx, ny, nz;
  logic signed [16:0]    absx, absy, absz;
  logic [15:0]           ax, ay, az, ma;
  logic signed [16:0]    sc, tc;
  logic [17:0]           ssum, tsum;
  logic [2:0]            face;

  assign full   = held & q_full;
  assign take   = push & ~full;
  assign q_push = held;
  assign q_data = ent;

  always_comb begin
    ex   = {dir_x[15], dir_x};
    ey   = {dir_y[15], dir_y};
    ez   = {dir_z[15], dir_z};
    nx   = -ex;
    ny   = -ey;
    nz   = -ez;
    absx = dir_x[15] ? nx : ex;
    absy = dir_y[15] ? ny : ey;
    absz = dir_z[15] ? nz : ez;
    ax   = absx[15:0];
    ay   = absy[15:0];
    az   = absz[15:0];
    // major axis, ties favor x then y
    if (ax >= ay && ax >= az) begin
      ma = ax;
      tc = ny;
      if (!dir_x[15] && dir_x != '0) begin
        face = cms_pkg::FACE_PX;
        sc   = nz;
      end else begin
        face = cms_pkg::FACE_NX;
        sc   = ez;
      end
    end else if (ay >= az) begin
      ma = ay;
      sc = ex;
      if (!dir_y[15]) begin
        face = cms_pkg::FACE_PY;
        tc   = ez;
      end else begin
        face = cms_pkg::FACE_NY;
        tc   = nz;
      end
    end else begin
      ma = az;
      tc = ny;
      if (!dir_z[15]) begin
        face = cms_pkg::FACE_PZ;
        sc   = ex;
      end else begin
        face = cms_pkg::FACE_NZ;
        sc   = nx;
      end
    end
    // face coordinate offset to [0, 2*ma]
    ssum = {sc[16], sc} + {2'b00, ma};
    tsum = {tc[16], tc} + {2'b00, ma};

    ent_next.op   = operation;
    ent_next.face = (operation == cms_pkg::OP_WRITE) ? face_index : face;
    ent_next.zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    ent_next.ma   = ma;
    ent_next.sx   = ssum[16:0];
    ent_next.sy   = tsum[16:0];
    ent_next.tx   = texel_x;
    ent_next.ty   = texel_y;
    ent_next.rgb  = {red_in, green_in, blue_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (!q_full) begin
      held <= 1'b0;
    end
    if (take) begin
      ent <= ent_next;
    end
  end

endmodule

// ===== rtl/core/cms_back.sv =====
module cms_back #(
  parameter int MAX_EDGE = cms_pkg::DEF_MAX_EDGE
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [6:0]     edge_size,
  input  logic           q_empty,
  input  cms_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output cms_pkg::res_t  res
);

  localparam int EW   = $clog2(MAX_EDGE + 1);
  localparam int CW   = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
  localparam int QW   = $clog2(256 * MAX_EDGE + 1);
  localparam int PRW  = 17 + EW;
  localparam int NW   = PRW + 7;
  localparam int MW   = 16 + QW;
  localparam int RW   = (NW > MW) ? NW : MW;
  localparam int HW   = QW - 7;
  localparam int FT   = MAX_EDGE * MAX_EDGE;
  localparam int DEPTH = cms_pkg::FACES * FT;
  localparam int AW   = $clog2(DEPTH);
  localparam int LAT  = QW + 7;
  localparam int OUT_DEPTH = 1 << $clog2(LAT / 2 + 4);
  localparam int OW   = $clog2(OUT_DEPTH + 1);
  localparam int RESW = $bits(cms_pkg::res_t);

  typedef struct packed {
    logic        op;
    logic        zero;
    logic [2:0]  face;
    logic [5:0]  tx;
    logic [5:0]  ty;
    logic [47:0] rgb;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic        wok;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [AW-1:0] a00;
    logic [AW-1:0] a10;
    logic [AW-1:0] a01;
    logic [AW-1:0] a11;
  } mem_t;

  // issue and credit
  logic            samp_last;
  logic [OW-1:0]   reserved;
  logic            credit_ok;
  logic            pop_samp;
  logic            out_rd;
  logic [EW-1:0]   n_reg;
  logic [EW-1:0]   n_next;

  // divider pipeline
  logic [QW:0]     dvld;
  tag_t            dtag [QW+1];
  logic [15:0]     dma  [QW+1];
  logic [RW-1:0]   rx   [QW+1];
  logic [RW-1:0]   ry   [QW+1];
  logic [QW-1:0]   qx   [QW+1];
  logic [QW-1:0]   qy   [QW+1];
  logic [QW-1:0]   gex;
  logic [QW-1:0]   gey;
  logic [RW-1:0]   dv   [QW];
  logic [PRW-1:0]  prx, pry;

  // address stage
  logic [QW:0]     vx, vy;
  logic [HW-1:0]   hx, hy;
  logic [EW-1:0]   nm1;
  logic [EW-1:0]   xa, xb, ya, yb;
  logic [AW-1:0]   fbase, wbase;
  mem_t            a_next;
  logic            m1vld, m2vld, m3vld;
  mem_t            m1, m2, m3;
  logic [47:0]     row0, row1;

  // ram
  logic            ram_we;
  logic [AW-1:0]   ra0, ra1;
  logic [47:0]     rd0, rd1;

  // blend
  logic            b1vld;
  tag_t            b1tag;
  logic [7:0]      b1fy;
  logic [24:0]     bla [3];
  logic [24:0]     blb [3];
  logic [24:0]     la_next [3];
  logic [24:0]     lb_next [3];
  logic [8:0]      wx0;
  logic [8:0]      wy0;
  logic [32:0]     rsum [3];
  cms_pkg::res_t   res_next;
  logic            out_push;
  logic [RESW-1:0] out_rdata;

  // ---- issue: a sample holds the read ports for both of its rows ----
  assign credit_ok = (reserved < OW'(OUT_DEPTH));
  assign q_pop = ~q_empty &
                 ((q_data.op == cms_pkg::OP_WRITE) | (credit_ok & ~samp_last));
  assign pop_samp = q_pop & (q_data.op == cms_pkg::OP_SAMPLE);
  assign out_rd   = pop & ~empty;

  always_comb begin
    if (edge_size == '0) begin
      n_next = EW'(1);
    end else if (32'(edge_size) > MAX_EDGE) begin
      n_next = EW'(MAX_EDGE);
    end else begin
      n_next = EW'(edge_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samp_last <= 1'b0;
      reserved  <= '0;
    end else begin
      samp_last <= pop_samp;
      reserved  <= reserved + OW'(pop_samp) - OW'(out_rd);
    end
    n_reg <= n_next;
  end

  // ---- scale by edge size, then one quotient bit per stage ----
  assign prx = q_data.sx * n_reg;
  assign pry = q_data.sy * n_reg;

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      dv[i]  = RW'(dma[i]) << (QW - 1 - i);
      gex[i] = (rx[i] >= dv[i]);
      gey[i] = (ry[i] >= dv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else begin
      dvld <= {dvld[QW-1:0], q_pop};
    end
    dtag[0].op   <= q_data.op;
    dtag[0].zero <= q_data.zero;
    dtag[0].face <= q_data.face;
    dtag[0].tx   <= q_data.tx;
    dtag[0].ty   <= q_data.ty;
    dtag[0].rgb  <= q_data.rgb;
    dma[0]       <= q_data.ma;
    rx[0]        <= RW'({prx, 7'b0});
    ry[0]        <= RW'({pry, 7'b0});
    qx[0]        <= '0;
    qy[0]        <= '0;
    for (int i = 0; i < QW; i++) begin
      dtag[i+1] <= dtag[i];
      dma[i+1]  <= dma[i];
      rx[i+1]   <= gex[i] ? (rx[i] - dv[i]) : rx[i];
      ry[i+1]   <= gey[i] ? (ry[i] - dv[i]) : ry[i];
      qx[i+1]   <= qx[i] | (QW'(gex[i]) << (QW - 1 - i));
      qy[i+1]   <= qy[i] | (QW'(gey[i]) << (QW - 1 - i));
    end
  end

  // ---- texel coordinates, clamped to the face, and addresses ----
  always_comb begin
    vx  = {1'b0, qx[QW]} + (QW+1)'(128);
    vy  = {1'b0, qy[QW]} + (QW+1)'(128);
    hx  = vx[QW:8];
    hy  = vy[QW:8];
    nm1 = n_reg - 1'b1;
    xb  = (hx > HW'(nm1)) ? nm1 : EW'(hx);
    yb  = (hy > HW'(nm1)) ? nm1 : EW'(hy);
    xa  = (hx == '0) ? '0 : ((hx - 1'b1 > HW'(nm1)) ? nm1 : EW'(hx - 1'b1));
    ya  = (hy == '0) ? '0 : ((hy - 1'b1 > HW'(nm1)) ? nm1 : EW'(hy - 1'b1));
    fbase = AW'(dtag[QW].face) * AW'(FT);
    wbase = fbase + AW'(CW'(dtag[QW].ty)) * AW'(MAX_EDGE) + AW'(CW'(dtag[QW].tx));

    a_next.tag = dtag[QW];
    a_next.wok = (32'(dtag[QW].face) < cms_pkg::FACES) &&
                 (32'(dtag[QW].tx) < MAX_EDGE) && (32'(dtag[QW].ty) < MAX_EDGE);
    a_next.fx  = vx[7:0];
    a_next.fy  = vy[7:0];
    if (dtag[QW].op == cms_pkg::OP_WRITE) begin
      a_next.a00 = wbase;
    end else begin
      a_next.a00 = fbase + AW'(CW'(ya)) * AW'(MAX_EDGE) + AW'(CW'(xa));
    end
    a_next.a10 = fbase + AW'(CW'(ya)) * AW'(MAX_EDGE) + AW'(CW'(xb));
    a_next.a01 = fbase + AW'(CW'(yb)) * AW'(MAX_EDGE) + AW'(CW'(xa));
    a_next.a11 = fbase + AW'(CW'(yb)) * AW'(MAX_EDGE) + AW'(CW'(xb));
  end

  // ---- two reads: top row from m1, bottom row from m2 ----
  assign ram_we = m1vld & (m1.tag.op == cms_pkg::OP_WRITE) & m1.wok;
  assign ra0 = (m2vld && m2.tag.op == cms_pkg::OP_SAMPLE) ? m2.a01 : m1.a00;
  assign ra1 = (m2vld && m2.tag.op == cms_pkg::OP_SAMPLE) ? m2.a11 : m1.a10;

  cms_ram #(
    .WIDTH (48),
    .DEPTH (DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (m1.a00),
    .wdata  (m1.tag.rgb),
    .raddr0 (ra0),
    .raddr1 (ra1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m1vld <= 1'b0;
      m2vld <= 1'b0;
      m3vld <= 1'b0;
    end else begin
      m1vld <= dvld[QW];
      m2vld <= m1vld;
      m3vld <= m2vld;
    end
    m1   <= a_next;
    m2   <= m1;
    m3   <= m2;
    row0 <= rd0;
    row1 <= rd1;
  end

  // ---- horizontal blend, then vertical blend and rounding ----
  always_comb begin
    wx0 = 9'd256 - {1'b0, m3.fx};
    for (int c = 0; c < 3; c++) begin
      la_next[c] = row0[47-16*c -: 16] * wx0 + row1[47-16*c -: 16] * {1'b0, m3.fx};
      lb_next[c] = rd0[47-16*c -: 16] * wx0 + rd1[47-16*c -: 16] * {1'b0, m3.fx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1vld <= 1'b0;
    end else begin
      b1vld <= m3vld & (m3.tag.op == cms_pkg::OP_SAMPLE);
    end
    b1tag <= m3.tag;
    b1fy  <= m3.fy;
    for (int c = 0; c < 3; c++) begin
      bla[c] <= la_next[c];
      blb[c] <= lb_next[c];
    end
  end

  always_comb begin
    wy0 = 9'd256 - {1'b0, b1fy};
    for (int c = 0; c < 3; c++) begin
      rsum[c] = bla[c] * wy0 + blb[c] * {1'b0, b1fy} + 33'd32768;
    end
    if (b1tag.zero) begin
      res_next.rgb  = '0;
      res_next.face = '0;
      res_next.zero = 1'b1;
    end else begin
      res_next.rgb  = {rsum[0][31:16], rsum[1][31:16], rsum[2][31:16]};
      res_next.face = b1tag.face;
      res_next.zero = 1'b0;
    end
  end

  assign out_push = b1vld;

  // room is reserved at issue, so this queue never overflows
  cms_fifo #(
    .WIDTH (RESW),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (res_next),
    .full  (),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign res = cms_pkg::res_t'(out_rdata);

endmodule

// ===== rtl/core/cube_map_bilinear_sampler_core.sv =====
// channel   dir  handshake               word
// input     in   push / full             operation, face, texel xy, rgb, direction
// result    out  empty / pop             red/green/blue_out, face_hit, zero_direction
// config    in   cfg_valid / cfg_ready   cfg_data: edge size in use
//
// Texel writes are taken one per cycle while the work queue has room; a sample
// cannot directly follow another sample, since its four texels are read from the
// two read ports of the texel store, top row first, bottom row after. Samples pass
// the 15-bit face-coordinate divider (MAX_EDGE 64), then address, read and blend.
// Reset clears control only; the texel store holds garbage until written.
// The front and back stall on their own; a result queue with no unreserved room holds off samples.
module cube_map_bilinear_sampler_core #(
  parameter int MAX_EDGE = cms_pkg::DEF_MAX_EDGE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [2:0]         face_index,
  input  logic [5:0]         texel_x,
  input  logic [5:0]         texel_y,
  input  logic [15:0]        red_in,
  input  logic [15:0]        green_in,
  input  logic [15:0]        blue_in,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        red_out,
  output logic [15:0]        green_out,
  output logic [15:0]        blue_out,
  output logic [2:0]         face_hit,
  output logic               zero_direction,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  localparam logic [6:0] EDGE_RESET  = 7'd64;
  localparam int         QUEUE_DEPTH = 4;
  localparam int         QEW         = $bits(cms_pkg::qent_t);

  logic [6:0]      edge_size;
  logic            q_push;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  cms_pkg::qent_t  q_in;
  logic [QEW-1:0]  q_out;
  cms_pkg::res_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_size <= EDGE_RESET;
    end else if (cfg_valid) begin
      edge_size <= cfg_data;
    end
  end

  cms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .face_index (face_index),
    .texel_x    (texel_x),
    .texel_y    (texel_y),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  cms_fifo #(
    .WIDTH (QEW),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_out),
    .empty (q_empty)
  );

  cms_back #(
    .MAX_EDGE (MAX_EDGE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .edge_size (edge_size),
    .q_empty   (q_empty),
    .q_data    (cms_pkg::qent_t'(q_out)),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign red_out        = res.rgb[47:32];
  assign green_out      = res.rgb[31:16];
  assign blue_out       = res.rgb[15:0];
  assign face_hit       = res.face;
  assign zero_direction = res.zero;

endmodule
